// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold while out of reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

`endif

// ===== hw/rtl/ect_pkg.sv =====
// shared constants, types and calendar functions for the civil time converter
package ect_pkg;

   localparam int NUM_STAGES = 8;

   // seconds per day split as 2^7 * 675, quotient by reciprocal multiply
   localparam logic [16:0] SECS_PER_DAY = 17'd86400;
   localparam int DAY_SHIFT = 7;
   localparam logic [25:0] DAY_RECIP = 26'd50903317;
   localparam int DAY_RECIP_SHIFT = 35;

   // year estimate, about days / 365.25
   localparam logic [15:0] YEAR_RECIP = 16'd45933;
   localparam int YEAR_RECIP_SHIFT = 24;

   // hour: 3600 = 16 * 225
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam int HOUR_SHIFT = 4;
   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam int HOUR_RECIP_SHIFT = 21;

   // minute: 60 = 4 * 15
   localparam logic [5:0] SECS_PER_MIN = 6'd60;
   localparam int MIN_SHIFT = 2;
   localparam logic [10:0] MIN_RECIP = 11'd1093;
   localparam int MIN_RECIP_SHIFT = 14;

   localparam logic [11:0] YEAR_BASE = 12'd1978;
   localparam logic [11:0] YEAR_SKIP_LEAP = 12'd2100;

   // per-stage load enables shared by the pipeline parts
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } stage_ctl_type;

   // leap rule over 1978..2115: divisible by 4, century 2100 excluded
   function automatic logic year_is_leap(input logic [7:0] idx);
      logic [11:0] yr;
      yr = YEAR_BASE + 12'(idx);
      return (yr[1:0] == 2'd0) && (yr != YEAR_SKIP_LEAP);
   endfunction

   // days from the epoch to jan 1 of year 1978 + idx
   function automatic logic [15:0] year_start(input logic [7:0] idx);
      logic [11:0] last_yr;
      logic [9:0]  leaps;
      last_yr = YEAR_BASE - 12'd1 + 12'(idx);
      leaps = last_yr[11:2] - 10'd494;
      if (last_yr >= YEAR_SKIP_LEAP) begin
         leaps = leaps - 10'd1;
      end
      return 16'(16'(idx) * 16'd365) + 16'(leaps);
   endfunction

   // day of year at which month m (0 based) starts
   function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
      logic [8:0] base;
      case (m)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (m >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

// ===== hw/rtl/ect_channels.sv =====
// valid/ready channel interfaces for request and response items
interface ect_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface ect_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day_of_month;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;

   modport source (output valid, output valid_res, output year, output month,
                   output day_of_month, output hour, output minute, output second,
                   input ready);
   modport sink (input valid, input valid_res, input year, input month,
                 input day_of_month, input hour, input minute, input second,
                 output ready);
endinterface

// ===== hw/rtl/ect_tod_split.sv =====
// time of day pipeline: seconds of day into hour, minute and second
module ect_tod_split (
   input  logic                  clock,
   input  ect_pkg::stage_ctl_type ctl,
   input  logic [16:0]           tod,
   output logic [4:0]            hour,
   output logic [5:0]            minute,
   output logic [5:0]            second
);

   logic [26:0] hprod4_ff, hprod4_in;
   logic [16:0] tod4_ff;
   logic [4:0]  hour5_ff, hour5_in;
   logic [11:0] rem5_ff, rem5_in;
   logic [16:0] hsec5;
   logic [20:0] mprod6_ff, mprod6_in;
   logic [11:0] rem6_ff;
   logic [4:0]  hour6_ff;
   logic [5:0]  min7_ff, min7_in;
   logic [5:0]  sec7_ff, sec7_in;
   logic [11:0] msec7;
   logic [4:0]  hour7_ff;
   logic [4:0]  hour8_ff;
   logic [5:0]  min8_ff;
   logic [5:0]  sec8_ff;

   // stage 4: hour quotient product
   assign hprod4_in = 27'(tod[16:ect_pkg::HOUR_SHIFT]) * 27'(ect_pkg::HOUR_RECIP);

   // stage 5: hour and remaining seconds of the hour
   assign hour5_in = 5'(hprod4_ff >> ect_pkg::HOUR_RECIP_SHIFT);
   assign hsec5    = 17'(hour5_in) * 17'(ect_pkg::SECS_PER_HOUR);
   assign rem5_in  = 12'(tod4_ff - hsec5);

   // stage 6: minute quotient product
   assign mprod6_in = 21'(rem5_ff[11:ect_pkg::MIN_SHIFT]) * 21'(ect_pkg::MIN_RECIP);

   // stage 7: minute and second
   assign min7_in = 6'(mprod6_ff >> ect_pkg::MIN_RECIP_SHIFT);
   assign msec7   = 12'(min7_in) * 12'(ect_pkg::SECS_PER_MIN);
   assign sec7_in = 6'(rem6_ff - msec7);

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         hprod4_ff <= hprod4_in;
         tod4_ff   <= tod;
      end
      if (ctl.load[4]) begin
         hour5_ff <= hour5_in;
         rem5_ff  <= rem5_in;
      end
      if (ctl.load[5]) begin
         mprod6_ff <= mprod6_in;
         rem6_ff   <= rem5_ff;
         hour6_ff  <= hour5_ff;
      end
      if (ctl.load[6]) begin
         min7_ff  <= min7_in;
         sec7_ff  <= sec7_in;
         hour7_ff <= hour6_ff;
      end
      if (ctl.load[7]) begin
         hour8_ff <= hour7_ff;
         min8_ff  <= min7_ff;
         sec8_ff  <= sec7_ff;
      end
   end

   assign hour   = hour8_ff;
   assign minute = min8_ff;
   assign second = sec8_ff;

endmodule

// ===== hw/rtl/epoch_seconds_to_civil_time.sv =====
// Each item passes 8 register stages, from stage 1 input capture to the stage 8 output register.
// Throughput: one item per cycle while not stalled, through an 8-stage pipeline;
// its stages use reciprocal multiplies and table compares.
// Backpressure stalls only the stages that are full; bubbles are squeezed out.
// Reset (synchronous, active high) clears all stage valid bits; no clearing pass.
`include "assert_macros.svh"

module epoch_seconds_to_civil_time (
   input logic     clock,
   input logic     reset,
   ect_req_if.sink   req_ch,
   ect_rsp_if.source rsp_ch
);

   localparam int NS = ect_pkg::NUM_STAGES;

   ect_pkg::stage_ctl_type ctl;
   logic [NS-1:0] v_ff, v_in;
   logic [NS-1:0] rdy;

   // stage 1: input capture
   logic [31:0] sec1_ff;
   logic        nz1_ff;
   // stage 2: day quotient product
   logic [50:0] prod2_ff, prod2_in;
   logic [31:0] sec2_ff;
   logic        nz2_ff;
   // stage 3: days and seconds of day
   logic [15:0] days3_ff, days3_in;
   logic [16:0] tod3_ff, tod3_in;
   logic [32:0] dsec3;
   logic        nz3_ff;
   // stage 4: year estimate product
   logic [31:0] yprod4_ff, yprod4_in;
   logic [15:0] days4_ff;
   logic        nz4_ff;
   // stage 5: estimate and its bounds checks
   logic [7:0]  est5_ff, est5_in;
   logic        lo5_ff, lo5_in;
   logic        hi5_ff, hi5_in;
   logic [15:0] days5_ff;
   logic        nz5_ff;
   // stage 6: year, day of year, leap flag
   logic [7:0]  yi6;
   logic [8:0]  doy6_ff, doy6_in;
   logic        leap6_ff, leap6_in;
   logic [11:0] year6_ff, year6_in;
   logic        nz6_ff;
   // stage 7: month index
   logic [3:0]  mi7_ff, mi7_in;
   logic [8:0]  doy7_ff;
   logic        leap7_ff;
   logic [11:0] year7_ff;
   logic        nz7_ff;
   // stage 8: output register
   logic [3:0]  month8_ff, month8_in;
   logic [4:0]  day8_ff, day8_in;
   logic [11:0] year8_ff;
   logic        nz8_ff;

   logic [4:0] tod_hour;
   logic [5:0] tod_minute;
   logic [5:0] tod_second;

   // assertion terms
   logic doy_bad;
   logic date_ok;

   // stage ready chain and valid bits
   always_comb begin
      rdy[NS-1] = !v_ff[NS-1] || rsp_ch.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
      v_in[0] = rdy[0] ? req_ch.valid : v_ff[0];
      for (int i = 1; i < NS; i++) begin
         v_in[i] = rdy[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   assign ctl.load    = rdy;
   assign req_ch.ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // stage 2: (s >> 7) times reciprocal of 675
   assign prod2_in = 51'(sec1_ff[31:ect_pkg::DAY_SHIFT]) * 51'(ect_pkg::DAY_RECIP);

   // stage 3: whole days and remainder
   assign days3_in = 16'(prod2_ff >> ect_pkg::DAY_RECIP_SHIFT);
   assign dsec3    = 33'(days3_in) * 33'(ect_pkg::SECS_PER_DAY);
   assign tod3_in  = 17'(sec2_ff - dsec3[31:0]);

   // stage 4: year estimate product
   assign yprod4_in = 32'(days3_ff) * 32'(ect_pkg::YEAR_RECIP);

   // stage 5: check estimate against year start table
   assign est5_in = 8'(yprod4_ff >> ect_pkg::YEAR_RECIP_SHIFT);
   assign lo5_in  = days4_ff < ect_pkg::year_start(est5_in);
   assign hi5_in  = days4_ff >= ect_pkg::year_start(est5_in + 8'd1);

   // stage 6: corrected year index and day of year
   always_comb begin
      if (lo5_ff) begin
         yi6 = est5_ff - 8'd1;
      end else if (hi5_ff) begin
         yi6 = est5_ff + 8'd1;
      end else begin
         yi6 = est5_ff;
      end
   end
   assign doy6_in  = 9'(days5_ff - ect_pkg::year_start(yi6));
   assign leap6_in = ect_pkg::year_is_leap(yi6);
   assign year6_in = ect_pkg::YEAR_BASE + 12'(yi6);

   // stage 7: month by parallel compare with month starts
   always_comb begin
      mi7_in = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (doy6_ff >= ect_pkg::month_start(4'(m), leap6_ff)) begin
            mi7_in = 4'(m);
         end
      end
   end

   // stage 8: month and day, 1 based
   assign month8_in = mi7_ff + 4'd1;
   assign day8_in   = 5'(doy7_ff - ect_pkg::month_start(mi7_ff, leap7_ff)) + 5'd1;

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         sec1_ff <= req_ch.epoch_seconds;
         nz1_ff  <= req_ch.epoch_seconds != 32'd0;
      end
      if (ctl.load[1]) begin
         prod2_ff <= prod2_in;
         sec2_ff  <= sec1_ff;
         nz2_ff   <= nz1_ff;
      end
      if (ctl.load[2]) begin
         days3_ff <= days3_in;
         tod3_ff  <= tod3_in;
         nz3_ff   <= nz2_ff;
      end
      if (ctl.load[3]) begin
         yprod4_ff <= yprod4_in;
         days4_ff  <= days3_ff;
         nz4_ff    <= nz3_ff;
      end
      if (ctl.load[4]) begin
         est5_ff  <= est5_in;
         lo5_ff   <= lo5_in;
         hi5_ff   <= hi5_in;
         days5_ff <= days4_ff;
         nz5_ff   <= nz4_ff;
      end
      if (ctl.load[5]) begin
         doy6_ff  <= doy6_in;
         leap6_ff <= leap6_in;
         year6_ff <= year6_in;
         nz6_ff   <= nz5_ff;
      end
      if (ctl.load[6]) begin
         mi7_ff   <= mi7_in;
         doy7_ff  <= doy6_ff;
         leap7_ff <= leap6_ff;
         year7_ff <= year6_ff;
         nz7_ff   <= nz6_ff;
      end
      if (ctl.load[7]) begin
         month8_ff <= month8_in;
         day8_ff   <= day8_in;
         year8_ff  <= year7_ff;
         nz8_ff    <= nz7_ff;
      end
   end

   // time of day split runs alongside stages 4 to 8
   ect_tod_split u_tod_split (
      .clock  (clock),
      .ctl    (ctl),
      .tod    (tod3_ff),
      .hour   (tod_hour),
      .minute (tod_minute),
      .second (tod_second)
   );

   // response, all fields zero for a never item
   assign rsp_ch.valid        = v_ff[NS-1];
   assign rsp_ch.valid_res    = nz8_ff;
   assign rsp_ch.year         = nz8_ff ? year8_ff : 12'd0;
   assign rsp_ch.month        = nz8_ff ? month8_ff : 4'd0;
   assign rsp_ch.day_of_month = nz8_ff ? day8_ff : 5'd0;
   assign rsp_ch.hour         = nz8_ff ? tod_hour : 5'd0;
   assign rsp_ch.minute       = nz8_ff ? tod_minute : 6'd0;
   assign rsp_ch.second       = nz8_ff ? tod_second : 6'd0;

   // day of year beyond the year length
   assign doy_bad = (doy6_ff > 9'd365) || (!leap6_ff && (doy6_ff == 9'd365));

   // result fields inside the calendar ranges; day of month is checked only against its lower bound
   assign date_ok = (rsp_ch.month >= 4'd1) && (rsp_ch.month <= 4'd12) &&
                    (rsp_ch.day_of_month >= 5'd1) && (rsp_ch.hour <= 5'd23) &&
                    (rsp_ch.minute <= 6'd59) && (rsp_ch.second <= 6'd59) &&
                    (rsp_ch.year >= 12'd1978) && (rsp_ch.year <= 12'd2114);

   // year estimate is never off in both directions
   `ASSERT_NEVER(a_est_bounds, clock, reset, v_ff[4] && lo5_ff && hi5_ff)
   // day of year fits the year length
   `ASSERT_NEVER(a_doy_range, clock, reset, v_ff[5] && doy_bad)
   // every dated result lies in the calendar ranges
   `ASSERT_IMPLIES(a_date_range, clock, reset, rsp_ch.valid && rsp_ch.valid_res, date_ok)

endmodule

// ===== bench/tb_epoch_seconds_to_civil_time.sv =====
// testbench for the seconds-count to calendar date and time-of-day converter
`timescale 1ns / 100ps

module tb_epoch_seconds_to_civil_time;

   localparam int unsigned EPOCH_YEAR    = 1978;
   localparam int unsigned DAY_SECONDS   = 86400;
   localparam int unsigned SECS_IN_HOUR  = 3600;
   localparam int unsigned SECS_IN_MIN   = 60;
   localparam int unsigned LAST_YEAR     = 2114;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          HOLD_CYCLES   = 250;
   localparam int          SETTLE_CYCLES = 24;

   // one converted date as it leaves the block
   typedef struct packed {
      logic        valid_res;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } civil_time_type;

   typedef enum logic [1:0] {
      RSP_ALWAYS,
      RSP_RANDOM,
      RSP_PATTERN
   } rsp_mode_type;

   logic clock;
   logic reset;

   ect_req_if req_ch ();
   ect_rsp_if rsp_ch ();

   epoch_seconds_to_civil_time dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   civil_time_type pending_dates[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   bit             sender_gaps = 1'b0;
   bit             hold_request = 1'b0;
   rsp_mode_type   rsp_mode = RSP_ALWAYS;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // calendar helpers
   function automatic bit is_leap_year(input int unsigned yr);
      return ((yr % 400) == 0) || (((yr % 100) != 0) && ((yr % 4) == 0));
   endfunction

   function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mon);
      case (mon)
         2:            return is_leap_year(yr) ? 29 : 28;
         4, 6, 9, 11:  return 30;
         default:      return 31;
      endcase
   endfunction

   // expected date for one seconds count
   function automatic civil_time_type civil_time_of(input logic [31:0] stamp);
      civil_time_type ct;
      int unsigned days;
      int unsigned tod;
      int unsigned yr;
      int unsigned mon;
      ct = '0;
      if (stamp == 32'd0) begin
         return ct;
      end
      days = stamp / DAY_SECONDS;
      tod  = stamp % DAY_SECONDS;
      yr = EPOCH_YEAR;
      while (days >= (is_leap_year(yr) ? 366 : 365)) begin
         days -= is_leap_year(yr) ? 366 : 365;
         yr++;
      end
      mon = 1;
      while ((mon < 12) && (days >= days_in_month(yr, mon))) begin
         days -= days_in_month(yr, mon);
         mon++;
      end
      ct.valid_res    = 1'b1;
      ct.year         = 12'(yr);
      ct.month        = 4'(mon);
      ct.day_of_month = 5'(days + 1);
      ct.hour         = 5'(tod / SECS_IN_HOUR);
      ct.minute       = 6'((tod % SECS_IN_HOUR) / SECS_IN_MIN);
      ct.second       = 6'(tod % SECS_IN_MIN);
      return ct;
   endfunction

   // seconds count of a calendar instant, unclamped
   function automatic longint seconds_at(input int unsigned yr, input int unsigned mon,
                                         input int unsigned dd, input int unsigned hh,
                                         input int unsigned mm, input int unsigned ss);
      longint days;
      days = 0;
      for (int unsigned y = EPOCH_YEAR; y < yr; y++) begin
         days += is_leap_year(y) ? 366 : 365;
      end
      for (int unsigned m = 1; m < mon; m++) begin
         days += days_in_month(yr, m);
      end
      days += dd - 1;
      return days * DAY_SECONDS + hh * SECS_IN_HOUR + mm * SECS_IN_MIN + ss;
   endfunction

   function automatic logic [31:0] to_stamp(input longint v);
      if (v < 0) begin
         return 32'd0;
      end
      if (v > 64'hFFFF_FFFF) begin
         return 32'hFFFF_FFFF;
      end
      return v[31:0];
   endfunction

   // offer one item, with random bursts and gaps when enabled
   task automatic send_stamp(input logic [31:0] stamp);
      int gap;
      if (sender_gaps) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
               @(negedge clock);
               req_ch.valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         burst_left--;
      end
      @(negedge clock);
      req_ch.valid         <= 1'b1;
      req_ch.epoch_seconds <= stamp;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      pending_dates.push_back(civil_time_of(stamp));
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // mixed random stamp aimed at the interesting corners
   function automatic logic [31:0] random_stamp();
      int unsigned kind;
      int unsigned yr;
      int unsigned mon;
      longint      start;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: return $urandom;
         4, 5, 6: begin
            // either side of a month or year boundary
            yr  = $urandom_range(EPOCH_YEAR, LAST_YEAR - 1);
            mon = $urandom_range(1, 12);
            start = seconds_at(yr, mon, 1, 0, 0, 0);
            if ($urandom_range(0, 1)) begin
               return to_stamp(start + $urandom_range(0, 90));
            end
            return to_stamp(start - 1 - $urandom_range(0, 90));
         end
         7: begin
            // time-of-day edges on a random day
            start = longint'($urandom_range(0, 49709)) * DAY_SECONDS;
            case ($urandom_range(0, 6))
               0:       return to_stamp(start);
               1:       return to_stamp(start + 59);
               2:       return to_stamp(start + 60);
               3:       return to_stamp(start + 3599);
               4:       return to_stamp(start + 3600);
               5:       return to_stamp(start + DAY_SECONDS - 1);
               default: return to_stamp(start + $urandom_range(0, DAY_SECONDS - 1));
            endcase
         end
         8:       return $urandom_range(0, 200);
         default: begin
            if ($urandom_range(0, 1)) begin
               return 32'hFFFF_FFFF - $urandom_range(0, 100000000);
            end
            return $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31))
                                        : ~(32'd1 << $urandom_range(0, 31));
         end
      endcase
   endfunction

   // extremes, leap rules, month and year edges
   task automatic test_directed();
      logic [31:0] stamps[$];
      sender_gaps = 1'b0;
      rsp_mode = RSP_ALWAYS;
      stamps = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
      stamps.push_back(to_stamp(seconds_at(1978, 12, 31, 23, 59, 59)));
      stamps.push_back(to_stamp(seconds_at(1979, 1, 1, 0, 0, 0)));
      stamps.push_back(to_stamp(seconds_at(1980, 2, 29, 12, 30, 30)));
      stamps.push_back(to_stamp(seconds_at(1980, 3, 1, 0, 0, 0)));
      stamps.push_back(to_stamp(seconds_at(1980, 12, 31, 23, 59, 59)));
      stamps.push_back(to_stamp(seconds_at(2000, 2, 29, 0, 0, 0)));
      stamps.push_back(to_stamp(seconds_at(2000, 12, 31, 23, 59, 59)));
      stamps.push_back(to_stamp(seconds_at(2100, 2, 28, 23, 59, 59)));
      stamps.push_back(to_stamp(seconds_at(2100, 3, 1, 0, 0, 0)));
      stamps.push_back(to_stamp(seconds_at(2104, 2, 29, 0, 0, 0)));
      stamps.push_back(to_stamp(seconds_at(2114, 1, 1, 0, 0, 0)));
      foreach (stamps[i]) begin
         send_stamp(stamps[i]);
      end
      idle_sender();
   endtask

   // back-to-back items with the receiver always ready
   task automatic test_streaming();
      sender_gaps = 1'b0;
      rsp_mode = RSP_ALWAYS;
      repeat (30) send_stamp(random_stamp());
      idle_sender();
   endtask

   // long receiver hold-off so the pipeline fills and stalls its input
   task automatic test_back_pressure();
      sender_gaps = 1'b0;
      rsp_mode = RSP_RANDOM;
      hold_request = 1'b1;
      repeat (40) send_stamp(random_stamp());
      idle_sender();
   endtask

   // random items with changing sender and receiver idling
   task automatic test_random();
      int unsigned mode_pick;
      for (int n = 0; n < 360; n++) begin
         if ((n % 40) == 0) begin
            mode_pick = $urandom_range(0, 2);
            rsp_mode = rsp_mode_type'(mode_pick);
            sender_gaps = ($urandom_range(0, 3) != 0);
         end
         send_stamp(random_stamp());
      end
      idle_sender();
   endtask

   // receiver ready, with its own stall pattern and long hold-off
   initial begin
      int         hold_left;
      logic [7:0] stall_mask;
      int         phase;
      hold_left = 0;
      stall_mask = 8'hFF;
      phase = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (rsp_mode)
               RSP_ALWAYS:  rsp_ch.ready <= 1'b1;
               RSP_RANDOM:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: begin
                  rsp_ch.ready <= stall_mask[phase];
                  phase = (phase + 1) % 8;
                  if (phase == 0) begin
                     stall_mask = 8'($urandom) | 8'h01;
                  end
               end
            endcase
         end
      end
   end

   task automatic check_field(input string fname, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
         mismatch_count++;
      end
   endtask

   // compare each accepted result with the oldest expected date
   always @(posedge clock) begin
      civil_time_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_dates.size() == 0) begin
            $display("%0t: result with none expected, actual year %0d month %0d day %0d",
                     $time, rsp_ch.year, rsp_ch.month, rsp_ch.day_of_month);
            mismatch_count++;
         end else begin
            want = pending_dates.pop_front();
            check_field("valid_res", want.valid_res, rsp_ch.valid_res);
            check_field("year", want.year, rsp_ch.year);
            check_field("month", want.month, rsp_ch.month);
            check_field("day_of_month", want.day_of_month, rsp_ch.day_of_month);
            check_field("hour", want.hour, rsp_ch.hour);
            check_field("minute", want.minute, rsp_ch.minute);
            check_field("second", want.second, rsp_ch.second);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_dates.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // reset, tests, drain and verdict
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.epoch_seconds = 32'd0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_streaming();
      test_back_pressure();
      test_random();

      while (pending_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
